// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hcpp_pkg.sv =====
// Shared types and constants for the hard-core point placement unit.
`default_nettype none

package hcpp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS_DEF = 256;
  localparam int MD_W           = 15;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CNT_CFG_W      = 9;
  localparam int TRY_W          = 16;
  localparam int SLOT_W         = 8;
  localparam int TOTAL_W        = 9;

  localparam logic [CNT_CFG_W-1:0] NUCLEON_COUNT_RST = 9'd208;
  localparam logic [MD_W-1:0]      MIN_DISTANCE_RST  = 15'd102;
  localparam logic [TRY_W-1:0]     MAX_TRIES_RST     = 16'd1000;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUCLEON_COUNT = 2'd0,
    REG_MIN_DISTANCE  = 2'd1,
    REG_MAX_TRIES     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_PLACED  = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_SAMPLE  = 3'd2,
    ST_FORCED  = 3'd3,
    ST_IGNORED = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                         cmd;
    logic                         sample_ok;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic signed [COORD_BITS-1:0] cand_z;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [TOTAL_W-1:0]   placed_total;
    logic                 set_full;
    logic [TRY_W-1:0]     tries_now;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } dist_stat_t;

endpackage

`default_nettype wire

// ===== hdl/hard_core_point_placement_unit.sv =====
// Top level of the hard-core minimum-distance point placement unit.
//
//   Channel   Direction  Handshake             Payload
//   cfg       in         cfg_wr_en             cfg_index, cfg_data
//   in        in         in_valid / in_ready   in_data (in_item_t)
//   out       out        out_valid / out_ready out_data (out_item_t)
//
// A clear, an ignored offer, a sampling reject or an offer to an empty set goes from
// acceptance straight to the result state. An offer tested against stored points first
// passes the scan and drain states; the point memory delivers one stored point per cycle
// to the distance pipeline; a scan covers at most 255 points. in_ready is high only while
// the sequencer is idle. A result waits in the output register; the next item is taken
// meanwhile and holds its own result until that register is free. Reset empties the set.
`default_nettype none

module hard_core_point_placement_unit import hcpp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int TW    = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

  logic [CNT_CFG_W-1:0] nucleon_count;
  logic [MD_W-1:0]      min_distance;
  logic [TRY_W-1:0]     max_tries;
  logic [2*MD_W-1:0]    lim;

  state_t           state, state_next;
  in_item_t         item;
  logic [CNT_W-1:0] placed_count, placed_next;
  logic [TRY_W-1:0] try_count, try_next;
  logic [CNT_W-1:0] scan_idx;
  logic             rv;
  logic             hit_acc;

  logic             accept;
  logic             ram_re, ram_we;
  logic             done_fire;
  logic [TW-1:0]    target;
  logic             full;
  logic             ok0, ok;
  status_t          status_c;
  logic [SLOT_W-1:0] slot_c;
  point_t           cand, stored;
  dist_stat_t       dstat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign target = (TW'(nucleon_count) > TW'(MAX_POINTS)) ? TW'(MAX_POINTS)
                                                         : TW'(nucleon_count);
  assign full   = TW'(placed_count) >= target;

  assign cand.x = item.cand_x;
  assign cand.y = item.cand_y;
  assign cand.z = item.cand_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      nucleon_count <= NUCLEON_COUNT_RST;
      min_distance  <= MIN_DISTANCE_RST;
      max_tries     <= MAX_TRIES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUCLEON_COUNT: nucleon_count <= cfg_data[CNT_CFG_W-1:0];
        REG_MIN_DISTANCE:  min_distance  <= cfg_data[MD_W-1:0];
        REG_MAX_TRIES:     max_tries     <= cfg_data[TRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim <= (2*MD_W)'(min_distance) * (2*MD_W)'(min_distance);
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    done_fire  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_OFFER && in_data.sample_ok && !full &&
              placed_count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        if (scan_idx == placed_count - CNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rv && !dstat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          done_fire  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ok0         = 1'b0;
    ok          = 1'b0;
    status_c    = ST_IGNORED;
    placed_next = placed_count;
    try_next    = try_count;
    slot_c      = '0;
    if (item.cmd == CMD_CLEAR) begin
      status_c    = ST_CLEARED;
      placed_next = '0;
      try_next    = '0;
    end else if (!full) begin
      if (item.sample_ok) begin
        ok0      = !hit_acc;
        status_c = ok0 ? ST_PLACED : ST_OVERLAP;
      end else begin
        status_c = ST_SAMPLE;
      end
      ok = ok0;
      if (!ok0 && try_count >= max_tries) begin
        ok       = 1'b1;
        status_c = ST_FORCED;
      end
      if (ok) begin
        slot_c      = SLOT_W'(placed_count);
        placed_next = placed_count + CNT_W'(1);
        try_next    = '0;
      end else begin
        try_next = try_count + TRY_W'(1);
      end
    end
  end

  assign ram_we = done_fire && ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      placed_count <= '0;
      try_count    <= '0;
      scan_idx     <= '0;
      rv           <= 1'b0;
      hit_acc      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= ram_re;
      if (accept) begin
        scan_idx <= '0;
        hit_acc  <= 1'b0;
      end else begin
        if (ram_re) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (dstat.hit_valid && dstat.hit) begin
          hit_acc <= 1'b1;
        end
      end
      if (done_fire) begin
        placed_count <= placed_next;
        try_count    <= try_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (done_fire) begin
      out_data.status       <= status_c;
      out_data.slot         <= slot_c;
      out_data.placed_total <= TOTAL_W'(placed_next);
      out_data.set_full     <= TW'(placed_next) >= target;
      out_data.tries_now    <= try_next;
    end
  end

  hcpp_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (placed_count[AW-1:0]),
    .wdata (cand),
    .re    (ram_re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (stored)
  );

  hcpp_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rv),
    .stored   (stored),
    .cand     (cand),
    .md       (min_distance),
    .lim      (lim),
    .stat     (dstat)
  );

endmodule

`default_nettype wire

// ===== hdl/hcpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hcpp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hcpp_dist.sv =====
// Pipelined distance test of one stored point against the candidate.
`default_nettype none

module hcpp_dist import hcpp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_valid,
  input  wire point_t                stored,
  input  wire point_t                cand,
  input  wire logic [MD_W-1:0]       md,
  input  wire logic [2*MD_W-1:0]     lim,
  output dist_stat_t                 stat
);

  localparam int AD_W  = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MD_W;
  localparam int SUM_W = SQ_W + 2;

  function automatic logic [AD_W-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [AD_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[AD_W-1] ? (~d + AD_W'(1)) : d;
  endfunction

  logic [AD_W-1:0] adx, ady, adz;
  logic            near_c;
  logic            v1, near1;
  logic [MD_W-1:0] ax1, ay1, az1;
  logic [SQ_W-1:0] sqx_c, sqy_c, sqz_c;
  logic            v2, near2;
  logic [SQ_W-1:0] sqx2, sqy2, sqz2;
  logic [SUM_W-1:0] sum2;

  always_comb begin
    adx    = abs_diff(stored.x, cand.x);
    ady    = abs_diff(stored.y, cand.y);
    adz    = abs_diff(stored.z, cand.z);
    near_c = (adx < AD_W'(md)) && (ady < AD_W'(md)) && (adz < AD_W'(md));
    sqx_c  = SQ_W'(ax1) * SQ_W'(ax1);
    sqy_c  = SQ_W'(ay1) * SQ_W'(ay1);
    sqz_c  = SQ_W'(az1) * SQ_W'(az1);
    sum2   = SUM_W'(sqx2) + SUM_W'(sqy2) + SUM_W'(sqz2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rd_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    near1 <= near_c;
    ax1   <= adx[MD_W-1:0];
    ay1   <= ady[MD_W-1:0];
    az1   <= adz[MD_W-1:0];
    near2 <= near1;
    sqx2  <= sqx_c;
    sqy2  <= sqy_c;
    sqz2  <= sqz_c;
  end

  assign stat.busy      = v1 | v2;
  assign stat.hit_valid = v2;
  assign stat.hit       = near2 && (sum2 < SUM_W'(lim));

endmodule

`default_nettype wire

// ===== hdl/hcpp_checker.sv =====
// Port-level assertions for the placement unit and the bind that attaches them.
`default_nettype none

`include "assert_macros.svh"

module hcpp_checker import hcpp_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cfg_wr_en,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]     cfg_data,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire in_item_t             in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire out_item_t            out_data
);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transaction")
  `CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")
  `CHK_IMPL(a_clear_zero, out_valid && out_data.status == ST_CLEARED, out_data.placed_total == '0 && out_data.tries_now == '0 && out_data.slot == '0, "clear left state behind")
  `CHK_IMPL(a_slot_zero, out_valid && out_data.status != ST_PLACED && out_data.status != ST_FORCED, out_data.slot == '0, "slot set without placement")
  `CHK_IMPL(a_place_tries, out_valid && (out_data.status == ST_PLACED || out_data.status == ST_FORCED), out_data.tries_now == '0 && out_data.placed_total != '0, "placement did not reset tries")

endmodule

bind hard_core_point_placement_unit hcpp_checker u_hcpp_checker (.*);

`default_nettype wire

// ===== test/hard_core_point_placement_unit_tb.sv =====
// Self-checking testbench for the hard-core point placement unit with a built-in predictor.
`timescale 1ns / 1ps

module hard_core_point_placement_unit_tb;
  import hcpp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_BLOCKS
  } rx_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  point_t kept_points [MAX_POINTS_DEF];
  int unsigned kept_count = 0;
  int unsigned miss_count = 0;
  int unsigned cfg_count = NUCLEON_COUNT_RST;
  int unsigned cfg_min_dist = MIN_DISTANCE_RST;
  int unsigned cfg_max_tries = MAX_TRIES_RST;

  out_item_t placement_results_due [$];
  out_item_t due_result;
  status_t last_status;
  point_t cluster_center = '0;
  bit sender_gaps = 1'b1;
  int unsigned burst_left = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  rx_pattern_t rx_pattern = RX_ALWAYS;
  logic [8:0] rx_tick = '0;

  hard_core_point_placement_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("hard_core_point_placement_unit_tb failed");
    $finish;
  end

  function automatic int unsigned set_capacity();
    return (cfg_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_count;
  endfunction

  function automatic longint unsigned axis_gap(logic signed [COORD_BITS-1:0] a,
                                               logic signed [COORD_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic bit overlaps(point_t p);
    longint unsigned md;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned dz;
    md = cfg_min_dist;
    for (int j = 0; j < kept_count; j++) begin
      dx = axis_gap(kept_points[j].x, p.x);
      dy = axis_gap(kept_points[j].y, p.y);
      dz = axis_gap(kept_points[j].z, p.z);
      if (dx < md && dy < md && dz < md && dx * dx + dy * dy + dz * dz < md * md)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_placement(in_item_t item);
    out_item_t res;
    point_t cand;
    bit take;
    int unsigned target;
    target = set_capacity();
    res = '0;
    cand.x = item.cand_x;
    cand.y = item.cand_y;
    cand.z = item.cand_z;
    if (item.cmd == CMD_CLEAR) begin
      kept_count = 0;
      miss_count = 0;
      res.status = ST_CLEARED;
    end else if (kept_count >= target) begin
      res.status = ST_IGNORED;
    end else begin
      if (item.sample_ok) begin
        take = !overlaps(cand);
        res.status = take ? ST_PLACED : ST_OVERLAP;
      end else begin
        take = 1'b0;
        res.status = ST_SAMPLE;
      end
      if (!take && miss_count >= cfg_max_tries) begin
        take = 1'b1;
        res.status = ST_FORCED;
      end
      if (take) begin
        res.slot = kept_count[7:0];
        kept_points[kept_count] = cand;
        kept_count++;
        miss_count = 0;
      end else begin
        miss_count++;
      end
    end
    res.placed_total = kept_count[8:0];
    res.set_full = (kept_count >= target);
    res.tries_now = miss_count[15:0];
    return res;
  endfunction

  function automatic in_item_t build_item(logic cmd, logic ok, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] z);
    in_item_t it;
    it.cmd = cmd;
    it.sample_ok = ok;
    it.cand_x = x;
    it.cand_y = y;
    it.cand_z = z;
    return it;
  endfunction

  // Most offers lie in a spread scaled to the spacing around a center so overlaps are common.
  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned spread;
    int unsigned roll;
    spread = 2 * cfg_min_dist + 8;
    roll = $urandom_range(99);
    it.sample_ok = ($urandom_range(99) >= 12);
    if ($urandom_range(99) < 20) begin
      it.cand_x = 16'($urandom);
      it.cand_y = 16'($urandom);
      it.cand_z = 16'($urandom);
    end else begin
      it.cand_x = cluster_center.x + 16'($urandom_range(2 * spread) - spread);
      it.cand_y = cluster_center.y + 16'($urandom_range(2 * spread) - spread);
      it.cand_z = cluster_center.z + 16'($urandom_range(2 * spread) - spread);
    end
    if (roll < 5 || (kept_count >= set_capacity() && roll < 50))
      it.cmd = CMD_CLEAR;
    else
      it.cmd = CMD_OFFER;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (placement_results_due.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        due_result = placement_results_due.pop_front();
        check_field("status", out_data.status, due_result.status);
        check_field("slot", out_data.slot, due_result.slot);
        check_field("placed_total", out_data.placed_total, due_result.placed_total);
        check_field("set_full", out_data.set_full, due_result.set_full);
        check_field("tries_now", out_data.tries_now, due_result.tries_now);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick[7:0] == 8'd0)
      rx_pattern <= rx_pattern_t'($urandom_range(3));
    case (rx_pattern)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(1));
      RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
      default: out_ready <= !rx_tick[4];
    endcase
  end

  task automatic send_item(input in_item_t item);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0)
      burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    placement_results_due.push_back(predict_placement(item));
    last_status = placement_results_due[$].status;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (placement_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_NUCLEON_COUNT: cfg_count = data[CNT_CFG_W-1:0];
      REG_MIN_DISTANCE: cfg_min_dist = data[MD_W-1:0];
      REG_MAX_TRIES: cfg_max_tries = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] count_raw, input logic [CFG_W-1:0] dist_raw,
                           input logic [CFG_W-1:0] tries_raw);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_NUCLEON_COUNT, count_raw);
    write_reg(REG_MIN_DISTANCE, dist_raw);
    write_reg(REG_MAX_TRIES, tries_raw);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_basics();
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd5000, 16'sd5000, 16'sd5000));
    send_item(build_item(CMD_OFFER, 1'b1, -16'sd32768, -16'sd32768, -16'sd32768));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd32767, 16'sd32767, 16'sd32767));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd101));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd102));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd59, 16'sd59, -16'sd59));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sh5555, 16'shAAAA, 16'sh5555));
    send_item(build_item(CMD_OFFER, 1'b1, 16'shAAAA, 16'sh5555, 16'shAAAA));
    send_item(build_item(CMD_CLEAR, 1'b1, 16'sh7FFF, -16'sd1, 16'sh1234));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_CLEAR, 1'b0, 16'sd0, 16'sd0, 16'sd0));
  endtask

  task automatic test_forced_placement();
    configure(16'h0004, 16'd200, 16'd2);
    send_item(build_item(CMD_CLEAR, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd300, 16'sd300, 16'sd300));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd300, 16'sd300, 16'sd300));
    send_item(build_item(CMD_OFFER, 1'b0, -16'sd900, 16'sd900, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd310, 16'sd290, 16'sd300));
    drain();
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd300, 16'sd300, 16'sd300));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000));
    send_item(build_item(CMD_OFFER, 1'b1, -16'sd7000, 16'sd20, 16'sd20));
    // A limit of zero turns every failure into a placement.
    configure(16'h0003, 16'd200, 16'd0);
    send_item(build_item(CMD_CLEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd4000, 16'sd0, 16'sd0));
  endtask

  task automatic test_zero_count();
    configure(16'hFE00, 16'd102, 16'd1000);
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_CLEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd0, 16'sd0, 16'sd0));
  endtask

  task automatic test_max_spacing();
    configure(16'h0005, 16'hFFFF, 16'h0003);
    send_item(build_item(CMD_CLEAR, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd32767, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, -16'sd32768, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd100, 16'sd100, 16'sd100));
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd100, 16'sd100, 16'sd100));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd32766, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, 16'sd0));
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd0, 16'sd0, -16'sd32768));
  endtask

  // A count above capacity is clipped, so the set fills every slot of the store.
  task automatic test_full_capacity();
    in_item_t it;
    configure(16'h01FF, 16'h8000, 16'hFFFF);
    send_item(build_item(CMD_CLEAR, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    while (kept_count < set_capacity()) begin
      it = build_item(CMD_OFFER, ($urandom_range(31) != 0), 16'($urandom), 16'($urandom),
                      16'($urandom));
      send_item(it);
    end
    send_item(build_item(CMD_OFFER, 1'b1, 16'sd1, 16'sd2, 16'sd3));
    send_item(build_item(CMD_OFFER, 1'b0, 16'sd1, 16'sd2, 16'sd3));
  endtask

  task automatic test_random_phases();
    int unsigned useful;
    int unsigned n;
    int unsigned pause_at;
    int unsigned roll;
    logic [8:0] count_sel;
    logic [14:0] dist_sel;
    logic [15:0] tries_sel;
    useful = 0;
    while (useful < 1000) begin
      roll = $urandom_range(99);
      if (roll < 5) count_sel = 9'd0;
      else if (roll < 15) count_sel = 9'($urandom_range(25, 300));
      else count_sel = 9'($urandom_range(1, 24));
      roll = $urandom_range(99);
      if (roll < 15) dist_sel = 15'd0;
      else if (roll < 75) dist_sel = 15'($urandom_range(1, 400));
      else if (roll < 90) dist_sel = 15'($urandom_range(400, 32767));
      else dist_sel = 15'h7FFF;
      roll = $urandom_range(99);
      if (roll < 40) tries_sel = 16'($urandom_range(0, 2));
      else if (roll < 85) tries_sel = 16'($urandom_range(3, 12));
      else if (roll < 95) tries_sel = 16'($urandom_range(13, 1000));
      else tries_sel = 16'hFFFF;
      configure({7'($urandom), count_sel}, {1'($urandom), dist_sel}, tries_sel);
      cluster_center.x = 16'($urandom);
      cluster_center.y = 16'($urandom);
      cluster_center.z = 16'($urandom);
      sender_gaps = ($urandom_range(3) != 0);
      n = $urandom_range(60, 140);
      pause_at = ($urandom_range(2) == 0) ? $urandom_range(n - 1) : n;
      for (int k = 0; k < n; k++) begin
        if (k == pause_at)
          drain();
        send_item(random_item());
        if (last_status != ST_IGNORED)
          useful++;
      end
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_basics();
    test_forced_placement();
    test_zero_count();
    test_max_spacing();
    test_full_capacity();
    test_random_phases();
    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("hard_core_point_placement_unit_tb passed");
    else
      $display("hard_core_point_placement_unit_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hcpp_pkg.sv
hdl/hcpp_ram.sv
hdl/hcpp_dist.sv
hdl/hard_core_point_placement_unit.sv
hdl/hcpp_checker.sv
test/hard_core_point_placement_unit_tb.sv
